// ----- rtl/packed_trit_array_store_top_defines.svh -----
// Assertion macros for the packed trit array store.
// Included by the top level; expects clk and arst_n in scope.
`ifndef PACKED_TRIT_ARRAY_STORE_TOP_DEFINES_SVH
`define PACKED_TRIT_ARRAY_STORE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define PTAS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("ptas assertion failed");
`define PTAS_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("ptas forbidden condition seen");
`else
`define PTAS_ASSERT(lbl, prop)
`define PTAS_NEVER(lbl, cond)
`endif

`endif

// ----- rtl/ptas_pkg.sv -----
// Shared constants, types and the base-3 weight table of the packed trit store.
// No dependencies.
package ptas_pkg;

	localparam int WORD_COUNT      = 256;
	localparam int DIGITS_PER_WORD = 20;

	localparam int IDX_W   = 13;
	localparam int DIGIT_W = 2;
	localparam int DATA_W  = 32;
	localparam int WORD_AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int POS_W   = (DIGITS_PER_WORD > 1) ? $clog2(DIGITS_PER_WORD) : 1;

	localparam logic [31:0] CAPACITY = 32'(WORD_COUNT * DIGITS_PER_WORD);

	localparam int RECIP_SH = IDX_W + POS_W;
	localparam int RECIP_W  = RECIP_SH + 1;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SH) + DIGITS_PER_WORD - 1) / DIGITS_PER_WORD);
	localparam int PROD_W = IDX_W + RECIP_W;

	localparam logic [DIGIT_W-1:0] DIGIT_MAX = 2'd2;

	typedef logic [DATA_W-1:0] word_t;

	function automatic word_t pow3(input logic [POS_W-1:0] p);
		word_t r;
		case (p)
			0:       r = 32'd1;
			1:       r = 32'd3;
			2:       r = 32'd9;
			3:       r = 32'd27;
			4:       r = 32'd81;
			5:       r = 32'd243;
			6:       r = 32'd729;
			7:       r = 32'd2187;
			8:       r = 32'd6561;
			9:       r = 32'd19683;
			10:      r = 32'd59049;
			11:      r = 32'd177147;
			12:      r = 32'd531441;
			13:      r = 32'd1594323;
			14:      r = 32'd4782969;
			15:      r = 32'd14348907;
			16:      r = 32'd43046721;
			17:      r = 32'd129140163;
			18:      r = 32'd387420489;
			default: r = 32'd1162261467;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/ptas_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ptas_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/packed_trit_array_store_top.sv -----
// Top level of the packed trit store: sequencer, base-3 digit unit and word RAM.
// Depends on ptas_pkg, ptas_ram and packed_trit_array_store_top_defines.svh.
`include "packed_trit_array_store_top_defines.svh"

// Stores 5120 ternary digits, twenty to a 32-bit word in base 3, in a 256-word RAM.
// Each transfer reads or writes one digit; the block takes one item at a time and
// holds in_stall high while it works. An in-range request steps through S_DIV
// (word index by reciprocal multiply), S_POS (p = index mod 20, RAM read issued),
// S_RD (word captured) and S_DIG, where the digit unit peels one base-3 digit per
// cycle from the top of the word down to position p; a write goes on to S_WR to
// write the word back. An index beyond capacity ends in S_DIV with range_error.
// The store reads as zero right after reset: a valid flop per word masks unwritten
// words, so there is no clearing pass. A finished result waits in the output
// register while the next item is accepted.
module packed_trit_array_store_top
	import ptas_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_type,
	input  logic [IDX_W-1:0]   digit_index,
	input  logic [DIGIT_W-1:0] digit_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [DIGIT_W-1:0] read_digit,
	output logic               range_error
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_POS  = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_DIG  = 3'd4;
	localparam logic [2:0] S_WR   = 3'd5;

	localparam logic [POS_W-1:0] POS_TOP = POS_W'(DIGITS_PER_WORD - 1);

	logic [2:0]              state_q;
	logic                    req_q;
	logic [IDX_W-1:0]        idx_q;
	logic [DIGIT_W-1:0]      val_q;
	logic [IDX_W-1:0]        quot_q;
	logic [POS_W-1:0]        pos_q;
	logic [POS_W-1:0]        p_q;
	word_t                   w_q;
	word_t                   rem_q;
	logic [DIGIT_W-1:0]      cur_q;
	logic [WORD_COUNT-1:0]   valid_q;
	logic                    out_valid_q;
	logic [DIGIT_W-1:0]      read_digit_q;
	logic                    range_error_q;

	logic                    out_free;
	logic                    out_load;
	logic                    accept;
	logic                    idx_err;
	logic [PROD_W-1:0]       prod;
	logic [IDX_W-1:0]        idx_rem;
	logic [WORD_AW-1:0]      word_addr;
	word_t                   ram_rdata;
	word_t                   rd_word;
	word_t                   ram_wdata;
	logic                    ram_we;
	logic                    ram_re;
	word_t                   fac;
	logic                    ge1;
	logic                    ge2;
	logic [DIGIT_W-1:0]      digit;
	word_t                   sub;
	word_t                   cur_fac;
	word_t                   val_fac;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid   = out_valid_q;
	assign read_digit  = read_digit_q;
	assign range_error = range_error_q;

	assign out_load = out_free && (
		((state_q == S_DIV) && idx_err) ||
		((state_q == S_DIG) && (p_q == pos_q) && !req_q) ||
		(state_q == S_WR));

	assign idx_err   = (32'(idx_q) >= CAPACITY);
	assign prod      = PROD_W'(idx_q) * PROD_W'(RECIP);
	assign idx_rem   = idx_q - IDX_W'(quot_q * IDX_W'(DIGITS_PER_WORD));
	assign word_addr = WORD_AW'(quot_q);
	assign rd_word   = valid_q[word_addr] ? ram_rdata : '0;

	// shared digit unit: weight of the current position, used by scan and write-back
	assign fac   = pow3((state_q == S_WR) ? pos_q : p_q);
	assign ge2   = {1'b0, rem_q} >= {fac, 1'b0};
	assign ge1   = rem_q >= fac;
	assign digit = ge2 ? 2'd2 : (ge1 ? 2'd1 : 2'd0);
	assign sub   = ge2 ? {fac[DATA_W-2:0], 1'b0} : (ge1 ? fac : '0);

	assign cur_fac   = (cur_q == 2'd2) ? {fac[DATA_W-2:0], 1'b0} :
	                   ((cur_q == 2'd1) ? fac : '0);
	assign val_fac   = (val_q == 2'd2) ? {fac[DATA_W-2:0], 1'b0} :
	                   ((val_q == 2'd1) ? fac : '0);
	assign ram_wdata = w_q + val_fac - cur_fac;

	assign ram_re = (state_q == S_POS);
	assign ram_we = (state_q == S_WR) && out_free;

	ptas_ram #(
		.WIDTH(DATA_W),
		.DEPTH(WORD_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(word_addr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(word_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			valid_q       <= '0;
			out_valid_q   <= 1'b0;
			read_digit_q  <= '0;
			range_error_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (idx_err) begin
						if (out_free) begin
							read_digit_q  <= '0;
							range_error_q <= 1'b1;
							state_q       <= S_IDLE;
						end
					end else begin
						state_q <= S_POS;
					end
				end
				S_POS: begin
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_DIG;
				end
				S_DIG: begin
					if (p_q == pos_q) begin
						if (req_q) begin
							state_q <= S_WR;
						end else if (out_free) begin
							read_digit_q  <= digit;
							range_error_q <= 1'b0;
							state_q       <= S_IDLE;
						end
					end
				end
				S_WR: begin
					if (out_free) begin
						valid_q[word_addr] <= 1'b1;
						read_digit_q  <= '0;
						range_error_q <= 1'b0;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					req_q <= req_type;
					idx_q <= digit_index;
					val_q <= (digit_value > DIGIT_MAX) ? DIGIT_MAX : digit_value;
				end
			end
			S_DIV: begin
				quot_q <= prod[RECIP_SH +: IDX_W];
			end
			S_POS: begin
				pos_q <= idx_rem[POS_W-1:0];
			end
			S_RD: begin
				w_q   <= rd_word;
				rem_q <= rd_word;
				p_q   <= POS_TOP;
			end
			S_DIG: begin
				if (p_q == pos_q) begin
					cur_q <= digit;
				end else begin
					rem_q <= rem_q - sub;
					p_q   <= p_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	`PTAS_ASSERT(a_accept_starts, accept |=> state_q == S_DIV)
	`PTAS_ASSERT(a_scan_above_pos, state_q == S_DIG |-> p_q >= pos_q)
	`PTAS_NEVER(a_err_no_digit, out_valid_q && range_error_q && read_digit_q != 2'd0)
	`PTAS_ASSERT(a_write_marks_valid, ram_we |=> valid_q[$past(word_addr)])

endmodule
